// File: rtl/core/smbp_pkg.sv
// Shared types and constants of the size-matched buffer pool.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package smbp_pkg;

	localparam int POOL_DEPTH      = 16;
	localparam int IDX_W           = 4;
	localparam int CNT_W           = 5;
	localparam int DIM_BITS        = 16;
	localparam int HANDLE_BITS     = 16;
	localparam int BYTES_W         = 35;
	localparam int AGE_W           = 16;
	localparam int CTR_W           = 32;
	localparam int BUSY_W          = 16;
	localparam int BYTES_PER_PIXEL = 4;
	localparam int APB_ADDR_W      = 5;
	localparam int APB_DATA_W      = 64;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	// request kinds
	typedef enum logic [1:0] {
		REQ_ACQUIRE = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_TICK    = 2'd2,
		REQ_CLEAR   = 2'd3
	} req_kind_t;

	// result codes
	typedef enum logic [2:0] {
		ST_REUSED    = 3'd0,
		ST_ALLOC     = 3'd1,
		ST_NO_TARGET = 3'd2,
		ST_STORED    = 3'd3,
		ST_DROPPED   = 3'd4,
		ST_IGNORED   = 3'd5,
		ST_TICKED    = 3'd6,
		ST_CLEARED   = 3'd7
	} rsp_status_t;

	// register indexes (byte address is 8 * index)
	typedef enum logic [1:0] {
		REG_MAX_ENTRIES    = 2'd0,
		REG_MAX_BYTES      = 2'd1,
		REG_DEVICE_PRESENT = 2'd2,
		REG_NONE           = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_ACQ,
		S_REL,
		S_TICK,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_MUL,
		CMD_ACQ_HIT,
		CMD_ACQ_NEXT,
		CMD_ACQ_MISS,
		CMD_IGNORE,
		CMD_DROP,
		CMD_EVICT,
		CMD_STORE,
		CMD_AGE,
		CMD_TICK_DROP,
		CMD_TICK_NEXT,
		CMD_TICK_END,
		CMD_CLEAR
	} cmd_t;

	typedef struct packed {
		cmd_t op;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		req_kind_t kind;
		logic      rvalid;
		logic      scan_end;
		logic      match;
		logic      drop;
		logic      evict_need;
		logic      age_over;
	} dp_stat_t;

	typedef struct packed {
		logic [CNT_W-1:0]   max_entries;
		logic [BYTES_W-1:0] max_bytes;
		logic               device_present;
	} cfg_t;

endpackage

// File: rtl/core/smbp_if.sv
// Request and result channel interfaces of the buffer pool.
// Depends on smbp_pkg for field widths.
interface smbp_req_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       req_type;
	logic [smbp_pkg::DIM_BITS-1:0]    width;
	logic [smbp_pkg::DIM_BITS-1:0]    height;
	logic [smbp_pkg::HANDLE_BITS-1:0] handle;
	logic                             release_valid;
	logic [smbp_pkg::BUSY_W-1:0]      busy_mask;
	logic [smbp_pkg::AGE_W-1:0]       idle_limit;

	modport source (output valid, req_type, width, height, handle, release_valid,
		busy_mask, idle_limit, input ready);
	modport sink (input valid, req_type, width, height, handle, release_valid,
		busy_mask, idle_limit, output ready);
endinterface

interface smbp_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [2:0]                       status;
	logic [smbp_pkg::HANDLE_BITS-1:0] out_handle;
	logic [smbp_pkg::CNT_W-1:0]       evicted_now;
	logic [smbp_pkg::CNT_W-1:0]       entries_held;
	logic [smbp_pkg::BYTES_W-1:0]     bytes_held;
	logic [smbp_pkg::CTR_W-1:0]       reuse_total;
	logic [smbp_pkg::CTR_W-1:0]       alloc_total;
	logic [smbp_pkg::CTR_W-1:0]       evict_total;

	modport source (output valid, status, out_handle, evicted_now, entries_held,
		bytes_held, reuse_total, alloc_total, evict_total, input ready);
	modport sink (input valid, status, out_handle, evicted_now, entries_held,
		bytes_held, reuse_total, alloc_total, evict_total, output ready);
endinterface

// File: rtl/core/smbp_cfg.sv
// APB-style register file: count limit, byte budget, device present.
// Depends on smbp_pkg.
module smbp_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [smbp_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [smbp_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [smbp_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	output smbp_pkg::cfg_t                       cfg
);

	smbp_pkg::cfg_t     cfg_q;
	smbp_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = smbp_pkg::reg_idx_t'(paddr[4:3]);
	assign wr_en  = psel & penable & pwrite & pready & (paddr[2:0] == 3'd0);
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_entries    <= smbp_pkg::CNT_W'(smbp_pkg::POOL_DEPTH);
			cfg_q.max_bytes      <= smbp_pkg::BYTES_W'(64'd67108864);
			cfg_q.device_present <= 1'b1;
		end else if (wr_en) begin
			case (idx)
				smbp_pkg::REG_MAX_ENTRIES:    cfg_q.max_entries <= pwdata[smbp_pkg::CNT_W-1:0];
				smbp_pkg::REG_MAX_BYTES:      cfg_q.max_bytes <= pwdata[smbp_pkg::BYTES_W-1:0];
				smbp_pkg::REG_DEVICE_PRESENT: cfg_q.device_present <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			smbp_pkg::REG_MAX_ENTRIES:    prdata = smbp_pkg::APB_DATA_W'(cfg_q.max_entries);
			smbp_pkg::REG_MAX_BYTES:      prdata = smbp_pkg::APB_DATA_W'(cfg_q.max_bytes);
			smbp_pkg::REG_DEVICE_PRESENT: prdata = smbp_pkg::APB_DATA_W'(cfg_q.device_present);
			default:                      prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/smbp_ctrl.sv
// Controller state machine: sequences scans, evictions and aging steps.
// Depends on smbp_pkg; drives the datapath by dp_cmd_t, reads dp_stat_t.
module smbp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  smbp_pkg::dp_stat_t stat,
	output smbp_pkg::dp_cmd_t  cmd
);

	smbp_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	assign out_valid = out_valid_q;

	// state register and result-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= smbp_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd.op       = smbp_pkg::CMD_NONE;
		cmd.out_load = 1'b0;
		in_ready     = 1'b0;
		case (state_q)
			smbp_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = smbp_pkg::CMD_LATCH;
					state_d = smbp_pkg::S_DECODE;
				end
			end
			smbp_pkg::S_DECODE: begin
				case (stat.kind)
					smbp_pkg::REQ_ACQUIRE: state_d = smbp_pkg::S_ACQ;
					smbp_pkg::REQ_RELEASE: begin
						if (stat.rvalid) begin
							cmd.op  = smbp_pkg::CMD_MUL;
							state_d = smbp_pkg::S_REL;
						end else begin
							cmd.op  = smbp_pkg::CMD_IGNORE;
							state_d = smbp_pkg::S_DONE;
						end
					end
					smbp_pkg::REQ_TICK: begin
						cmd.op  = smbp_pkg::CMD_AGE;
						state_d = smbp_pkg::S_TICK;
					end
					default: begin
						cmd.op  = smbp_pkg::CMD_CLEAR;
						state_d = smbp_pkg::S_DONE;
					end
				endcase
			end
			smbp_pkg::S_ACQ: begin
				if (stat.scan_end) begin
					cmd.op  = smbp_pkg::CMD_ACQ_MISS;
					state_d = smbp_pkg::S_DONE;
				end else if (stat.match) begin
					cmd.op  = smbp_pkg::CMD_ACQ_HIT;
					state_d = smbp_pkg::S_DONE;
				end else begin
					cmd.op = smbp_pkg::CMD_ACQ_NEXT;
				end
			end
			smbp_pkg::S_REL: begin
				if (stat.drop) begin
					cmd.op  = smbp_pkg::CMD_DROP;
					state_d = smbp_pkg::S_DONE;
				end else if (stat.evict_need) begin
					cmd.op = smbp_pkg::CMD_EVICT;
				end else begin
					cmd.op  = smbp_pkg::CMD_STORE;
					state_d = smbp_pkg::S_DONE;
				end
			end
			smbp_pkg::S_TICK: begin
				if (stat.scan_end) begin
					cmd.op  = smbp_pkg::CMD_TICK_END;
					state_d = smbp_pkg::S_DONE;
				end else if (stat.age_over) begin
					cmd.op = smbp_pkg::CMD_TICK_DROP;
				end else begin
					cmd.op = smbp_pkg::CMD_TICK_NEXT;
				end
			end
			smbp_pkg::S_DONE: begin
				// hand the beat to the output register once it is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = smbp_pkg::S_IDLE;
				end
			end
			default: state_d = smbp_pkg::S_IDLE;
		endcase
	end

endmodule

// File: rtl/core/smbp_dp.sv
// Datapath: pool entries, byte estimate, counters and the result register.
// Depends on smbp_pkg; commanded by smbp_ctrl.
module smbp_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  smbp_pkg::dp_cmd_t                    cmd,
	output smbp_pkg::dp_stat_t                   stat,
	input  smbp_pkg::cfg_t                       cfg,
	input  logic [1:0]                           in_req_type,
	input  logic [smbp_pkg::DIM_BITS-1:0]        in_width,
	input  logic [smbp_pkg::DIM_BITS-1:0]        in_height,
	input  logic [smbp_pkg::HANDLE_BITS-1:0]     in_handle,
	input  logic                                 in_release_valid,
	input  logic [smbp_pkg::BUSY_W-1:0]          in_busy_mask,
	input  logic [smbp_pkg::AGE_W-1:0]           in_idle_limit,
	output logic [2:0]                           status,
	output logic [smbp_pkg::HANDLE_BITS-1:0]     out_handle,
	output logic [smbp_pkg::CNT_W-1:0]           evicted_now,
	output logic [smbp_pkg::CNT_W-1:0]           entries_held,
	output logic [smbp_pkg::BYTES_W-1:0]         bytes_held,
	output logic [smbp_pkg::CTR_W-1:0]           reuse_total,
	output logic [smbp_pkg::CTR_W-1:0]           alloc_total,
	output logic [smbp_pkg::CTR_W-1:0]           evict_total
);

	localparam int D = smbp_pkg::POOL_DEPTH;

	// pool entries, oldest at position 0
	logic [smbp_pkg::DIM_BITS-1:0]    w_q  [D];
	logic [smbp_pkg::DIM_BITS-1:0]    h_q  [D];
	logic [smbp_pkg::BYTES_W-1:0]     b_q  [D];
	logic [smbp_pkg::HANDLE_BITS-1:0] hd_q [D];
	logic [smbp_pkg::AGE_W-1:0]       age_q[D];

	logic [smbp_pkg::CNT_W-1:0]   count_q;
	logic [smbp_pkg::BYTES_W-1:0] total_q;
	logic [smbp_pkg::CTR_W-1:0]   reuse_q, alloc_q, evict_q;

	// latched request
	smbp_pkg::req_kind_t              kind_q;
	logic [smbp_pkg::DIM_BITS-1:0]    rw_q, rh_q;
	logic [smbp_pkg::HANDLE_BITS-1:0] rhd_q;
	logic                             rvalid_q;
	logic [smbp_pkg::BUSY_W-1:0]      busy_q;
	logic [smbp_pkg::AGE_W-1:0]       limit_q;
	logic [smbp_pkg::BYTES_W-1:0]     est_q;
	logic [smbp_pkg::CNT_W-1:0]       idx_q;
	logic [smbp_pkg::CNT_W-1:0]       evicted_q;
	smbp_pkg::rsp_status_t            status_q;
	logic [smbp_pkg::HANDLE_BITS-1:0] ohandle_q;

	// result register
	logic [2:0]                       o_status_q;
	logic [smbp_pkg::HANDLE_BITS-1:0] o_handle_q;
	logic [smbp_pkg::CNT_W-1:0]       o_evicted_q, o_count_q;
	logic [smbp_pkg::BYTES_W-1:0]     o_total_q;
	logic [smbp_pkg::CTR_W-1:0]       o_reuse_q, o_alloc_q, o_evict_q;

	logic [smbp_pkg::IDX_W-1:0]   sidx;
	logic                         rm_en;
	logic [smbp_pkg::IDX_W-1:0]   rm_pos;
	logic [smbp_pkg::CNT_W-1:0]   lim;
	logic [smbp_pkg::BYTES_W-1:0] room;
	logic [2*smbp_pkg::DIM_BITS-1:0] prod;

	assign sidx   = idx_q[smbp_pkg::IDX_W-1:0];
	assign rm_en  = (cmd.op == smbp_pkg::CMD_ACQ_HIT) || (cmd.op == smbp_pkg::CMD_EVICT) ||
		(cmd.op == smbp_pkg::CMD_TICK_DROP);
	assign rm_pos = (cmd.op == smbp_pkg::CMD_EVICT) ? '0 : sidx;
	assign lim    = (cfg.max_entries > smbp_pkg::CNT_W'(D)) ? smbp_pkg::CNT_W'(D) :
		cfg.max_entries;
	assign room   = cfg.max_bytes - est_q;
	assign prod   = rw_q * rh_q;

	// status to controller
	always_comb begin
		stat.kind       = kind_q;
		stat.rvalid     = rvalid_q;
		stat.scan_end   = (idx_q >= count_q);
		stat.match      = (w_q[sidx] == rw_q) && (h_q[sidx] == rh_q) &&
			!(busy_q[sidx]);
		stat.drop       = (cfg.max_entries == '0) || (est_q == '0) ||
			(est_q > cfg.max_bytes);
		stat.evict_need = (count_q != '0) && ((count_q >= lim) || (total_q > room));
		stat.age_over   = (age_q[sidx] > limit_q);
	end

	// entry storage: shift-down removal, append, aging
	always_ff @(posedge clk) begin
		for (int i = 0; i < D; i++) begin
			if (rm_en && (smbp_pkg::IDX_W'(i) >= rm_pos) && (i < D - 1)) begin
				w_q[i]   <= w_q[i+1];
				h_q[i]   <= h_q[i+1];
				b_q[i]   <= b_q[i+1];
				hd_q[i]  <= hd_q[i+1];
				age_q[i] <= age_q[i+1];
			end
			if (cmd.op == smbp_pkg::CMD_AGE && age_q[i] != smbp_pkg::AGE_MAX)
				age_q[i] <= age_q[i] + 1'b1;
		end
		if (cmd.op == smbp_pkg::CMD_STORE) begin
			w_q[count_q[smbp_pkg::IDX_W-1:0]]   <= rw_q;
			h_q[count_q[smbp_pkg::IDX_W-1:0]]   <= rh_q;
			b_q[count_q[smbp_pkg::IDX_W-1:0]]   <= est_q;
			hd_q[count_q[smbp_pkg::IDX_W-1:0]]  <= rhd_q;
			age_q[count_q[smbp_pkg::IDX_W-1:0]] <= '0;
		end
	end

	// fill level, byte total and running counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
			reuse_q <= '0;
			alloc_q <= '0;
			evict_q <= '0;
		end else begin
			case (cmd.op)
				smbp_pkg::CMD_ACQ_HIT: begin
					count_q <= count_q - 1'b1;
					total_q <= total_q - b_q[sidx];
					reuse_q <= reuse_q + 1'b1;
				end
				smbp_pkg::CMD_ACQ_MISS: if (cfg.device_present) alloc_q <= alloc_q + 1'b1;
				smbp_pkg::CMD_DROP: evict_q <= evict_q + 1'b1;
				smbp_pkg::CMD_EVICT: begin
					count_q <= count_q - 1'b1;
					total_q <= total_q - b_q[0];
					evict_q <= evict_q + 1'b1;
				end
				smbp_pkg::CMD_STORE: begin
					count_q <= count_q + 1'b1;
					total_q <= total_q + est_q;
				end
				smbp_pkg::CMD_TICK_DROP: begin
					count_q <= count_q - 1'b1;
					total_q <= total_q - b_q[sidx];
					evict_q <= evict_q + 1'b1;
				end
				smbp_pkg::CMD_CLEAR: begin
					count_q <= '0;
					total_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			smbp_pkg::CMD_LATCH: begin
				kind_q    <= smbp_pkg::req_kind_t'(in_req_type);
				rw_q      <= in_width;
				rh_q      <= in_height;
				rhd_q     <= in_handle;
				rvalid_q  <= in_release_valid;
				busy_q    <= in_busy_mask;
				limit_q   <= in_idle_limit;
				idx_q     <= '0;
				evicted_q <= '0;
				ohandle_q <= '0;
			end
			smbp_pkg::CMD_MUL:
				est_q <= smbp_pkg::BYTES_W'(prod) *
					smbp_pkg::BYTES_W'(smbp_pkg::BYTES_PER_PIXEL);
			smbp_pkg::CMD_ACQ_NEXT, smbp_pkg::CMD_TICK_NEXT: idx_q <= idx_q + 1'b1;
			smbp_pkg::CMD_ACQ_HIT: begin
				ohandle_q <= hd_q[sidx];
				status_q  <= smbp_pkg::ST_REUSED;
			end
			smbp_pkg::CMD_ACQ_MISS:
				status_q <= cfg.device_present ? smbp_pkg::ST_ALLOC : smbp_pkg::ST_NO_TARGET;
			smbp_pkg::CMD_IGNORE: status_q <= smbp_pkg::ST_IGNORED;
			smbp_pkg::CMD_DROP: begin
				status_q  <= smbp_pkg::ST_DROPPED;
				evicted_q <= smbp_pkg::CNT_W'(1);
			end
			smbp_pkg::CMD_EVICT, smbp_pkg::CMD_TICK_DROP: evicted_q <= evicted_q + 1'b1;
			smbp_pkg::CMD_STORE: status_q <= smbp_pkg::ST_STORED;
			smbp_pkg::CMD_TICK_END: status_q <= smbp_pkg::ST_TICKED;
			smbp_pkg::CMD_CLEAR: status_q <= smbp_pkg::ST_CLEARED;
			default: ;
		endcase
	end

	// result register, loaded once per request
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_status_q  <= status_q;
			o_handle_q  <= ohandle_q;
			o_evicted_q <= evicted_q;
			o_count_q   <= count_q;
			o_total_q   <= total_q;
			o_reuse_q   <= reuse_q;
			o_alloc_q   <= alloc_q;
			o_evict_q   <= evict_q;
		end
	end

	assign status       = o_status_q;
	assign out_handle   = o_handle_q;
	assign evicted_now  = o_evicted_q;
	assign entries_held = o_count_q;
	assign bytes_held   = o_total_q;
	assign reuse_total  = o_reuse_q;
	assign alloc_total  = o_alloc_q;
	assign evict_total  = o_evict_q;

endmodule

// File: rtl/core/size_matched_buffer_pool.sv
// Top level of the size-matched buffer pool.
// Depends on smbp_pkg, smbp_if, smbp_cfg, smbp_ctrl and smbp_dp.
//
// Usage:
//   req is a valid/ready channel carrying one request per beat: acquire,
//   release, age tick or clear. rsp returns exactly one result beat per
//   request, in order. The APB-style port sets the count limit, the byte
//   budget and device presence; write it only while the pool is idle.
// Sequencing:
//   A request is latched, decoded in the next cycle and then worked one
//   pool position per cycle by the controller: an acquire scans up to the
//   fill level (up to 16 positions), a release first computes the byte
//   estimate and then evicts from the oldest end as needed, a tick ages all
//   entries at once and then walks the list once. The result register is
//   then loaded once it is free, and the next request is taken as soon as
//   the previous one has reached the result register.
// Reset: the pool is empty, running counters are zero, limits return to
//   16 entries, 64 MiB and device present.
// Stall: a result waits in its register while rsp.ready is low; the next
//   request may already run and then waits at its end for the register.
module size_matched_buffer_pool (
	input  logic                                 clk,
	input  logic                                 arst_n,
	smbp_req_if.sink                             req,
	smbp_rsp_if.source                           rsp,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [smbp_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [smbp_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [smbp_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready
);

	smbp_pkg::cfg_t     cfg;
	smbp_pkg::dp_cmd_t  cmd;
	smbp_pkg::dp_stat_t stat;

	smbp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	smbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	smbp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg              (cfg),
		.in_req_type      (req.req_type),
		.in_width         (req.width),
		.in_height        (req.height),
		.in_handle        (req.handle),
		.in_release_valid (req.release_valid),
		.in_busy_mask     (req.busy_mask),
		.in_idle_limit    (req.idle_limit),
		.status           (rsp.status),
		.out_handle       (rsp.out_handle),
		.evicted_now      (rsp.evicted_now),
		.entries_held     (rsp.entries_held),
		.bytes_held       (rsp.bytes_held),
		.reuse_total      (rsp.reuse_total),
		.alloc_total      (rsp.alloc_total),
		.evict_total      (rsp.evict_total)
	);

endmodule
